FILE: hw/rtl/vsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_pkg
// shared types and codes of the voxel shape rasterizer
// ----------------------------------------------------------------------------
package vsr_pkg;

  localparam logic [1:0] CMD_BOX     = 2'd0;
  localparam logic [1:0] CMD_ELLIPSE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;
  localparam logic [1:0] REG_ALPHA = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SQ,
    ST_PROD,
    ST_SUM,
    ST_RMW,
    ST_READ,
    ST_RDATA,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic              carve;
    logic signed [7:0] coord_x;
    logic signed [7:0] coord_y;
    logic signed [7:0] coord_z;
    logic signed [7:0] span_x;
    logic signed [7:0] span_y;
    logic signed [7:0] span_z;
  } vsr_in_t;

  typedef struct packed {
    logic       in_grid;
    logic       voxel_on;
    logic [7:0] voxel_red;
    logic [7:0] voxel_green;
    logic [7:0] voxel_blue;
    logic [7:0] voxel_alpha;
  } vsr_out_t;

endpackage

FILE: hw/rtl/vsr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsr_in_if / vsr_out_if
// valid/ready channels of the voxel shape rasterizer
// ----------------------------------------------------------------------------
interface vsr_in_if import vsr_pkg::*; ();
  logic    valid;
  logic    ready;
  vsr_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface vsr_out_if import vsr_pkg::*; ();
  logic     valid;
  logic     ready;
  vsr_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/voxel_shape_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_shape_rasterizer
// voxel store with box and ellipsoid fill and single voxel read
// ----------------------------------------------------------------------------
// usage
//   cmd_in: one command per transfer (box, ellipsoid, read)
//   res_out: exactly one result per command, zeros for draw commands
//   apb port: paint colour registers at byte addresses 0,4,8,12
// timing
//   the store is one ram, one write and one registered read port, one entry per voxel
//   box: each visited voxel gets a read phase and a write back phase
//   ellipsoid: every voxel of the clipped bounding box goes through the test
//   steps square, product and sum, then a read-modify-write
//   read: the result sits in an output register
// reset
//   a clearing pass writes every entry while no command is accepted; apb
//   writes are taken meanwhile
// stall
//   a result held by the receiver blocks the next command until its
//   transfer; the store is untouched meanwhile
// ----------------------------------------------------------------------------
module voxel_shape_rasterizer import vsr_pkg::*; #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic        clk,
  input  logic        rst,
  vsr_in_if.sink      cmd_in,
  vsr_out_if.source   res_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int AW = $clog2(CELLS);

  // paint registers
  logic [7:0] paint_red, paint_green, paint_blue, paint_alpha;
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      paint_red <= '0; paint_green <= '0; paint_blue <= '0; paint_alpha <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        REG_RED:   paint_red   <= pwdata[7:0];
        REG_GREEN: paint_green <= pwdata[7:0];
        REG_BLUE:  paint_blue  <= pwdata[7:0];
        REG_ALPHA: paint_alpha <= pwdata[7:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[3:2])
      REG_RED:   prdata = {24'd0, paint_red};
      REG_GREEN: prdata = {24'd0, paint_green};
      REG_BLUE:  prdata = {24'd0, paint_blue};
      REG_ALPHA: prdata = {24'd0, paint_alpha};
      default:   prdata = '0;
    endcase
  end

  // voxel ram: on flag + rgba
  logic [32:0] ram [CELLS];
  logic [32:0] rdata;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [32:0] wdata;
  always_ff @(posedge clk) begin
    if (we) ram[waddr] <= wdata;
    rdata <= ram[raddr];
  end

  state_t state, state_next;
  logic [AW:0] clr_cnt;
  logic [1:0]  cmd;
  logic        carve;
  // clipped scan bounds and position, 10 bit signed covers -256..255 with margin
  logic signed [9:0] x, y, z, x_lo, y_lo, z_lo, x_hi, y_hi, z_hi;
  logic signed [9:0] cx, cy, cz;
  logic [7:0]  rx, ry, rz;
  // ellipsoid weights; radii up to 127 so r^2 <= 14 bits, weights 28 bits
  logic [13:0] rx2, ry2, rz2;
  logic [27:0] wx, wy, wz;
  logic [41:0] lim;
  logic [15:0] dx2, dy2, dz2;
  logic [43:0] px, py, pz;
  logic        hit;
  logic        last;
  vsr_out_t    res;
  logic        res_valid;
  logic [AW-1:0] addr;
  logic [2:0]  setup;

  function automatic logic signed [9:0] smax(logic signed [9:0] a, logic signed [9:0] b);
    return (a > b) ? a : b;
  endfunction
  function automatic logic signed [9:0] smin(logic signed [9:0] a, logic signed [9:0] b);
    return (a < b) ? a : b;
  endfunction
  function automatic logic [15:0] sq9(logic signed [9:0] v);
    logic [9:0] a;
    a = v[9] ? 10'(-v) : v;
    return 16'(a[7:0] * a[7:0]);
  endfunction

  assign addr = AW'((32'(x) * GRID_Y + 32'(y)) * GRID_Z + 32'(z));
  // last position of the z-fastest scan
  assign last = (z == z_hi - 10'sd1) && (y == y_hi - 10'sd1) && (x == x_hi - 10'sd1);

  assign cmd_in.ready = (state == ST_IDLE) && !res_valid;
  assign res_out.valid = res_valid;
  assign res_out.data = res;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == (AW+1)'(CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (cmd_in.valid && cmd_in.ready) state_next = ST_SCAN;
      ST_SCAN: begin
        // setup computes weights, then goes to read or checks for empty range or zero radius
        if (setup != 3'd0) state_next = ST_SCAN;
        else if (cmd == CMD_READ) state_next = ST_READ;
        else if (cmd == CMD_BOX && x_lo < x_hi && y_lo < y_hi && z_lo < z_hi)
          state_next = ST_RMW;
        else if (cmd == CMD_ELLIPSE && rx != 0 && ry != 0 && rz != 0 &&
                 x_lo < x_hi && y_lo < y_hi && z_lo < z_hi)
          state_next = ST_SQ;
        else state_next = ST_OUT;
      end
      ST_SQ:    state_next = ST_PROD;
      ST_PROD:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_RMW;
      ST_RMW:   if (last) state_next = ST_OUT;
                else state_next = (cmd == CMD_ELLIPSE) ? ST_SQ : ST_RMW;
      ST_READ:  state_next = ST_RDATA;
      ST_RDATA: state_next = ST_OUT;
      ST_OUT:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // memory control; box writes every visited voxel, ellipsoid only hits
  // (no true rmw needed for set, carve keeps the colour so it needs the read data)
  logic rmw_phase;
  always_comb begin
    we = 1'b0;
    waddr = addr;
    wdata = '0;
    raddr = addr;
    if (state == ST_CLEAR) begin
      we = 1'b1;
      waddr = clr_cnt[AW-1:0];
    end else if (state == ST_RMW && rmw_phase && (cmd == CMD_BOX || hit)) begin
      we = 1'b1;
      wdata = carve ? {1'b0, rdata[31:0]}
                    : {1'b1, paint_red, paint_green, paint_blue, paint_alpha};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      res_valid <= 1'b0;
      rmw_phase <= 1'b0;
      setup <= '0;
    end else begin
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (res_valid && res_out.ready) res_valid <= 1'b0;
      if (state == ST_OUT) res_valid <= 1'b1;
      if (state == ST_IDLE && cmd_in.valid && cmd_in.ready) setup <= 3'd2;
      else if (setup != 3'd0) setup <= setup - 1'b1;
      // rmw state holds for a read issue phase, then a write back phase
      if (state == ST_RMW) rmw_phase <= !rmw_phase;
      else rmw_phase <= 1'b0;
      if (!(state == ST_RMW && !rmw_phase)) state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_in.valid && cmd_in.ready) begin
      cmd <= cmd_in.data.cmd;
      carve <= cmd_in.data.carve;
      cx <= 10'(cmd_in.data.coord_x);
      cy <= 10'(cmd_in.data.coord_y);
      cz <= 10'(cmd_in.data.coord_z);
      rx <= cmd_in.data.span_x[7] ? 8'd0 : cmd_in.data.span_x;
      ry <= cmd_in.data.span_y[7] ? 8'd0 : cmd_in.data.span_y;
      rz <= cmd_in.data.span_z[7] ? 8'd0 : cmd_in.data.span_z;
      res <= '0;
      if (cmd_in.data.cmd == CMD_ELLIPSE) begin
        x_lo <= smax(10'(cmd_in.data.coord_x) - 10'(cmd_in.data.span_x), 10'sd0);
        y_lo <= smax(10'(cmd_in.data.coord_y) - 10'(cmd_in.data.span_y), 10'sd0);
        z_lo <= smax(10'(cmd_in.data.coord_z) - 10'(cmd_in.data.span_z), 10'sd0);
        x_hi <= smin(10'(cmd_in.data.coord_x) + 10'(cmd_in.data.span_x), 10'(GRID_X));
        y_hi <= smin(10'(cmd_in.data.coord_y) + 10'(cmd_in.data.span_y), 10'(GRID_Y));
        z_hi <= smin(10'(cmd_in.data.coord_z) + 10'(cmd_in.data.span_z), 10'(GRID_Z));
      end else begin
        x_lo <= smax(10'(cmd_in.data.coord_x), 10'sd0);
        y_lo <= smax(10'(cmd_in.data.coord_y), 10'sd0);
        z_lo <= smax(10'(cmd_in.data.coord_z), 10'sd0);
        x_hi <= smin(10'(cmd_in.data.span_x), 10'(GRID_X));
        y_hi <= smin(10'(cmd_in.data.span_y), 10'(GRID_Y));
        z_hi <= smin(10'(cmd_in.data.span_z), 10'(GRID_Z));
      end
    end
    if (state == ST_SCAN) begin
      if (setup == 3'd2) begin
        rx2 <= 14'(rx * rx); ry2 <= 14'(ry * ry); rz2 <= 14'(rz * rz);
      end else if (setup == 3'd1) begin
        wx <= 28'(ry2 * rz2); wy <= 28'(rx2 * rz2); wz <= 28'(rx2 * ry2);
      end else begin
        lim <= 42'(rx2 * wx);
        if (cmd == CMD_READ) begin
          x <= cx; y <= cy; z <= cz;
        end else begin
          x <= x_lo; y <= y_lo; z <= z_lo;
        end
      end
    end
    if (state == ST_SQ) begin
      dx2 <= sq9(x - cx); dy2 <= sq9(y - cy); dz2 <= sq9(z - cz);
    end
    if (state == ST_PROD) begin
      px <= 44'(dx2 * wx); py <= 44'(dy2 * wy); pz <= 44'(dz2 * wz);
    end
    if (state == ST_SUM) hit <= (46'(px) + 46'(py) + 46'(pz)) <= 46'(lim);
    if (state == ST_RMW && rmw_phase) begin
      if (z != z_hi - 10'sd1) z <= z + 10'sd1;
      else begin
        z <= z_lo;
        if (y != y_hi - 10'sd1) y <= y + 10'sd1;
        else begin
          y <= y_lo;
          x <= x + 10'sd1;
        end
      end
    end
    if (state == ST_RDATA) begin
      if (x >= 0 && y >= 0 && z >= 0 && x < 10'(GRID_X) && y < 10'(GRID_Y) &&
          z < 10'(GRID_Z)) begin
        res.in_grid <= 1'b1;
        res.voxel_on <= rdata[32];
        res.voxel_red <= rdata[31:24];
        res.voxel_green <= rdata[23:16];
        res.voxel_blue <= rdata[15:8];
        res.voxel_alpha <= rdata[7:0];
      end
    end
  end

endmodule
